>>> rtl/hmd5_pkg.sv
// Package: types and constants for the MD5 / HMAC-MD5 engine.
`default_nettype none
package hmd5_pkg;

  typedef enum logic [1:0] {
    CMD_KEY    = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] key_index;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        final_word;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,     // waiting for a transaction
    ST_KEYBLK,   // absorbing key XOR pad
    ST_MSGBYTE,  // absorbing the one message byte
    ST_PAD80,    // absorbing 0x80
    ST_PADZ,     // absorbing zeros up to 56 mod 64
    ST_LEN,      // absorbing the 8 length bytes
    ST_INNER,    // absorbing the inner digest bytes
    ST_ROUNDS,   // compressing a block
    ST_EMIT      // delivering the four digest words
  } state_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [7:0] IPAD = 8'h36;
  localparam logic [7:0] OPAD = 8'h5C;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  function automatic logic [31:0] round_add(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
      32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
      32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
      32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
      32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
      32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
      32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
      32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
      32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
      32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
      32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
      32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
      32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
      32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
      32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
      32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391};
    return k[i];
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] j);
    logic [4:0] s [16];
    s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return s[j];
  endfunction

  // Message word used by round i.
  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(5 * i[3:0] + 1);
      2'd2: g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

>>> rtl/md5_hmac_hash_engine.sv
// Top level: MD5 / HMAC-MD5 engine over a byte stream with a key store.
// One item at a time. A key byte is written as it is accepted; a message byte holds off the
// input while it is absorbed and, if it closes a block, for a load step and then 64 rounds,
// one per cycle. Keyed open: the key XOR 0x36 block (a key prefetch, 64 bytes), compressed.
// Finish: pad, length, key, inner digest bytes one per cycle, a step per key prefetch and per
// end of zero padding, a compression per block; then four output words, one per out_ready cycle.
// Synchronous active-high reset: key store is cleared by a sweep of its 64 bytes, during which
// no transaction is accepted; chaining words, counters and mode return to their reset values.
`default_nettype none
module md5_hmac_hash_engine (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire hmd5_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output hmd5_pkg::out_item_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata
);

  // Block store: 16 words, one byte lane written per byte absorb, one word read per round.
  logic [31:0] blk_mem [16];
  logic [7:0] key_mem [64];
  logic [31:0] blk_rd;

  hmd5_pkg::state_t state, state_next;
  logic        hmac_enable;
  logic        hmac_sample;     // mode of the hash being finished
  logic        outer;           // running the outer hash
  logic [63:0] byte_count;
  logic [63:0] bit_len;         // latched length for the length bytes
  logic        message_open;
  logic [31:0] cw [4];          // chaining words
  logic [31:0] ra, rb, rc, rd;  // round working registers
  logic [31:0] inner [4];
  logic [6:0]  cnt;             // step counter for multi-byte sequences
  logic [5:0]  round;
  logic        rd_pend;         // round read in flight
  logic        clr_busy;
  logic [5:0]  clr_ptr;
  hmd5_pkg::state_t ret_state;  // where to go after a compress
  logic [7:0]  key_rd;
  logic [5:0]  key_addr;
  logic [1:0]  emit_idx;
  logic [7:0]  pad_sel;
  logic [1:0]  cmd;
  logic [1:0]  held_cmd;        // command of the accepted transaction
  logic [7:0]  held_byte;       // message byte of the accepted transaction

  logic        absorb_en;
  logic [7:0]  absorb_byte;

  assign cmd = in_data.command;
  assign in_ready = (state == hmd5_pkg::ST_IDLE) && !clr_busy;

  // Key store read: registered, so in the key-block state the byte is fetched in the cycle before its absorb.
  assign key_addr = (state == hmd5_pkg::ST_KEYBLK && rd_pend) ? cnt[5:0] + 6'd1 : cnt[5:0];

  always_ff @(posedge clk) begin
    key_rd <= key_mem[key_addr];
  end

  // Byte to absorb in each state.
  always_comb begin
    absorb_en = 1'b0;
    absorb_byte = 8'h00;
    pad_sel = hmac_sample && outer ? hmd5_pkg::OPAD : hmd5_pkg::IPAD;
    case (state)
      hmd5_pkg::ST_KEYBLK: begin
        absorb_en = rd_pend;
        absorb_byte = key_rd ^ pad_sel;
      end
      hmd5_pkg::ST_MSGBYTE: begin
        absorb_en = 1'b1;
        absorb_byte = held_byte;
      end
      hmd5_pkg::ST_PAD80: begin
        absorb_en = 1'b1;
        absorb_byte = hmd5_pkg::PAD_BYTE;
      end
      hmd5_pkg::ST_PADZ: begin
        absorb_en = byte_count[5:0] != hmd5_pkg::LEN_POS;
        absorb_byte = 8'h00;
      end
      hmd5_pkg::ST_LEN: begin
        absorb_en = 1'b1;
        absorb_byte = bit_len[8*cnt[2:0] +: 8];
      end
      hmd5_pkg::ST_INNER: begin
        absorb_en = 1'b1;
        absorb_byte = inner[cnt[3:2]][8*cnt[1:0] +: 8];
      end
      default: ;
    endcase
  end

  // Round datapath.
  logic [31:0] f_val, t_val, rot_v;
  logic [4:0]  sh;
  always_comb begin
    case (round[5:4])
      2'd0: f_val = rd ^ (rb & (rc ^ rd));
      2'd1: f_val = rc ^ (rd & (rb ^ rc));
      2'd2: f_val = rb ^ rc ^ rd;
      default: f_val = rc ^ (rb | ~rd);
    endcase
    t_val = ra + f_val + blk_rd + hmd5_pkg::round_add(round);
    sh = hmd5_pkg::rot_amount({round[5:4], round[1:0]});
    rot_v = (t_val << sh) | (t_val >> (6'd32 - {1'b0, sh}));
  end

  logic last_byte_of_block;
  assign last_byte_of_block = absorb_en && (byte_count[5:0] == 6'd63);

  // Round whose word is fetched this cycle.
  logic [5:0] round_pre;
  assign round_pre = (state == hmd5_pkg::ST_ROUNDS && rd_pend) ? round + 6'd1 : 6'd0;

  // Memory port for the block store.
  always_ff @(posedge clk) begin
    if (absorb_en) begin
      blk_mem[byte_count[5:2]][8*byte_count[1:0] +: 8] <= absorb_byte;
    end
    blk_rd <= blk_mem[hmd5_pkg::word_sel(round_pre)];
  end

  always_ff @(posedge clk) begin
    if (clr_busy) begin
      key_mem[clr_ptr] <= 8'h00;
    end else if (in_valid && in_ready && cmd == hmd5_pkg::CMD_KEY) begin
      key_mem[in_data.key_index] <= in_data.data_byte;
    end
  end

  // Next state: a byte absorb closing a block diverts to the rounds.
  always_comb begin
    state_next = state;
    case (state)
      hmd5_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (cmd == hmd5_pkg::CMD_BYTE) begin
            state_next = (!message_open && hmac_enable) ? hmd5_pkg::ST_KEYBLK
                                                        : hmd5_pkg::ST_MSGBYTE;
          end else if (cmd == hmd5_pkg::CMD_FINISH) begin
            state_next = (!message_open && hmac_enable) ? hmd5_pkg::ST_KEYBLK
                                                        : hmd5_pkg::ST_PAD80;
          end
        end
      end
      hmd5_pkg::ST_KEYBLK: if (last_byte_of_block) state_next = hmd5_pkg::ST_ROUNDS;
      hmd5_pkg::ST_MSGBYTE: begin
        state_next = last_byte_of_block ? hmd5_pkg::ST_ROUNDS : hmd5_pkg::ST_IDLE;
      end
      hmd5_pkg::ST_PAD80: begin
        state_next = last_byte_of_block ? hmd5_pkg::ST_ROUNDS : hmd5_pkg::ST_PADZ;
      end
      hmd5_pkg::ST_PADZ: begin
        if (!absorb_en) state_next = hmd5_pkg::ST_LEN;
        else if (last_byte_of_block) state_next = hmd5_pkg::ST_ROUNDS;
      end
      hmd5_pkg::ST_LEN: if (last_byte_of_block) state_next = hmd5_pkg::ST_ROUNDS;
      hmd5_pkg::ST_INNER: begin
        if (last_byte_of_block) state_next = hmd5_pkg::ST_ROUNDS;
        else if (cnt[3:0] == 4'd15) state_next = hmd5_pkg::ST_PAD80;
      end
      hmd5_pkg::ST_ROUNDS: if (rd_pend && round == 6'd63) state_next = ret_state;
      hmd5_pkg::ST_EMIT: if (out_ready && emit_idx == 2'd3) state_next = hmd5_pkg::ST_IDLE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hmd5_pkg::ST_IDLE;
      hmac_enable <= 1'b0;
      hmac_sample <= 1'b0;
      outer <= 1'b0;
      byte_count <= '0;
      message_open <= 1'b0;
      cw[0] <= hmd5_pkg::IV0; cw[1] <= hmd5_pkg::IV1;
      cw[2] <= hmd5_pkg::IV2; cw[3] <= hmd5_pkg::IV3;
      cnt <= '0;
      round <= '0;
      rd_pend <= 1'b0;
      clr_busy <= 1'b1;
      clr_ptr <= '0;
      ret_state <= hmd5_pkg::ST_IDLE;
      emit_idx <= '0;
      held_cmd <= hmd5_pkg::CMD_NONE;
    end else begin
      if (cfg_we) hmac_enable <= cfg_wdata;
      if (clr_busy) begin
        clr_ptr <= clr_ptr + 6'd1;
        if (clr_ptr == 6'd63) clr_busy <= 1'b0;
      end
      state <= state_next;
      if (absorb_en) byte_count <= byte_count + 64'd1;
      case (state)
        hmd5_pkg::ST_IDLE: begin
          cnt <= '0;
          rd_pend <= 1'b0;
          if (in_valid && in_ready && (cmd == hmd5_pkg::CMD_BYTE ||
                                       cmd == hmd5_pkg::CMD_FINISH)) begin
            held_cmd <= cmd;
            held_byte <= in_data.data_byte;
            outer <= 1'b0;
            if (!message_open) begin
              // Open: reload IV, clear count, sample mode for the inner pad.
              message_open <= 1'b1;
              byte_count <= '0;
              hmac_sample <= hmac_enable;
              cw[0] <= hmd5_pkg::IV0; cw[1] <= hmd5_pkg::IV1;
              cw[2] <= hmd5_pkg::IV2; cw[3] <= hmd5_pkg::IV3;
            end
            ret_state <= (cmd == hmd5_pkg::CMD_BYTE) ? hmd5_pkg::ST_IDLE
                                                     : hmd5_pkg::ST_PADZ;
          end
        end
        hmd5_pkg::ST_KEYBLK: begin
          // Prefetch key byte then absorb one per cycle; drop the read flag for the rounds.
          rd_pend <= !last_byte_of_block;
          if (rd_pend) cnt <= cnt + 7'd1;
          ret_state <= (held_cmd == hmd5_pkg::CMD_BYTE || outer) ?
                       (outer ? hmd5_pkg::ST_INNER : hmd5_pkg::ST_MSGBYTE)
                       : hmd5_pkg::ST_PAD80;
        end
        hmd5_pkg::ST_MSGBYTE: begin
          ret_state <= hmd5_pkg::ST_IDLE;
        end
        hmd5_pkg::ST_PAD80: begin
          bit_len <= {byte_count[60:0], 3'b000};
          ret_state <= hmd5_pkg::ST_PADZ;
        end
        hmd5_pkg::ST_PADZ: begin
          cnt <= '0;
          ret_state <= hmd5_pkg::ST_PADZ;
        end
        hmd5_pkg::ST_LEN: begin
          cnt <= cnt + 7'd1;
          // Last length byte always closes a block; decide what follows.
          if (outer || !hmac_enable) begin
            ret_state <= hmd5_pkg::ST_EMIT;
          end else begin
            ret_state <= hmd5_pkg::ST_KEYBLK;
          end
        end
        hmd5_pkg::ST_INNER: begin
          cnt <= cnt + 7'd1;
          ret_state <= hmd5_pkg::ST_PAD80;
        end
        hmd5_pkg::ST_ROUNDS: begin
          if (!rd_pend) begin
            // Load working registers, word 0 is being read.
            rd_pend <= 1'b1;
            round <= '0;
            ra <= cw[0]; rb <= cw[1]; rc <= cw[2]; rd <= cw[3];
          end else if (round != 6'd63 || 1'b1) begin
            ra <= rd; rd <= rc; rc <= rb;
            rb <= rb + rot_v;
            round <= round + 6'd1;
            if (round == 6'd63) begin
              cw[0] <= cw[0] + rd;
              cw[1] <= cw[1] + rb + rot_v;
              cw[2] <= cw[2] + rb;
              cw[3] <= cw[3] + rc;
              rd_pend <= 1'b0;
              cnt <= '0;
              if (ret_state == hmd5_pkg::ST_KEYBLK) begin
                // Inner hash done: start outer hash over key XOR 0x5C.
                inner[0] <= cw[0] + rd;
                inner[1] <= cw[1] + rb + rot_v;
                inner[2] <= cw[2] + rb;
                inner[3] <= cw[3] + rc;
                cw[0] <= hmd5_pkg::IV0; cw[1] <= hmd5_pkg::IV1;
                cw[2] <= hmd5_pkg::IV2; cw[3] <= hmd5_pkg::IV3;
                byte_count <= '0;
                outer <= 1'b1;
                hmac_sample <= 1'b1;
              end
              if (ret_state == hmd5_pkg::ST_EMIT) begin
                message_open <= 1'b0;
                emit_idx <= '0;
              end
            end
          end
        end
        hmd5_pkg::ST_EMIT: begin
          if (out_ready) emit_idx <= emit_idx + 2'd1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state == hmd5_pkg::ST_EMIT);
  assign out_data.digest_word = cw[emit_idx];
  assign out_data.word_index = emit_idx;
  assign out_data.final_word = (emit_idx == 2'd3);

  // Checks.
  a_no_accept_clr: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !in_ready) else $error("accept during key clear");
  a_emit_open: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !message_open) else $error("emit with message open");
  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(emit_idx))
    else $error("emit dropped");
  a_round_seq: assert property (@(posedge clk) disable iff (rst)
    (state == hmd5_pkg::ST_ROUNDS && rd_pend && round != 6'd63) |=>
    round == $past(round) + 6'd1) else $error("round skip");

endmodule
`default_nettype wire

>>> tb/sv/md5_hmac_hash_engine_tb.sv
// Testbench for the MD5 / HMAC-MD5 engine: self-checking, with a digest predictor.
`default_nettype none

// Scoreboard: keeps its own copy of the hash state and queues expected digest words.
class hmac_md5_scoreboard;
  bit              hmac_mode;
  bit [31:0]       chain[4];
  bit [7:0]        blk[64];
  bit [63:0]       absorbed;
  bit [7:0]        key[64];
  bit              msg_open;
  bit [31:0]       sine_add[64];
  int unsigned     shift_by[16];
  hmd5_pkg::out_item_t digest_q[$];
  int              mismatches;
  int              results_seen;
  int              finishes;

  function new();
    real r;
    shift_by = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    // Round additives are floor(|sin(i+1)| * 2^32).
    for (int i = 0; i < 64; i++) begin
      r = $sin(i + 1);
      if (r < 0.0) r = -r;
      sine_add[i] = 32'(longint'($floor(r * 4294967296.0)));
    end
    hmac_mode = 0;
    load_iv();
    absorbed = '0;
    msg_open = 0;
    foreach (key[i]) key[i] = '0;
    foreach (blk[i]) blk[i] = '0;
  endfunction

  function void load_iv();
    chain = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476};
  endfunction

  function void compress();
    bit [31:0] w[16];
    bit [31:0] a, b, c, d, f, t;
    int g;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i+3], blk[4*i+2], blk[4*i+1], blk[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = d ^ (b & (c ^ d)); g = i; end
        1: begin f = c ^ (d & (b ^ c)); g = (5 * i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
      endcase
      t = a + f + w[g] + sine_add[i];
      a = d; d = c; c = b;
      b = b + ((t << shift_by[(i / 16) * 4 + i % 4]) |
               (t >> (32 - shift_by[(i / 16) * 4 + i % 4])));
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endfunction

  function void absorb(bit [7:0] v);
    blk[absorbed[5:0]] = v;
    absorbed++;
    if (absorbed[5:0] == 0) compress();
  endfunction

  function void absorb_key(bit [7:0] pad);
    for (int i = 0; i < 64; i++) absorb(key[i] ^ pad);
  endfunction

  function void pad_length();
    bit [63:0] bits;
    bits = absorbed << 3;
    absorb(8'h80);
    while (absorbed[5:0] != 6'd56) absorb(8'h00);
    for (int i = 0; i < 8; i++) absorb(bits[8*i +: 8]);
  endfunction

  function void open_msg();
    load_iv();
    absorbed = '0;
    msg_open = 1;
    if (hmac_mode) absorb_key(8'h36);
  endfunction

  function int pending();
    return digest_q.size();
  endfunction

  // Update the state for one accepted input transaction.
  function void note_input(hmd5_pkg::in_item_t it);
    bit [31:0] inner[4];
    hmd5_pkg::out_item_t o;
    case (hmd5_pkg::cmd_t'(it.command))
      hmd5_pkg::CMD_KEY: key[it.key_index] = it.data_byte;
      hmd5_pkg::CMD_BYTE: begin
        if (!msg_open) open_msg();
        absorb(it.data_byte);
      end
      hmd5_pkg::CMD_FINISH: begin
        if (!msg_open) open_msg();
        pad_length();
        if (hmac_mode) begin
          inner = chain;
          load_iv();
          absorbed = '0;
          absorb_key(8'h5C);
          for (int i = 0; i < 16; i++) absorb(inner[i / 4][8*(i%4) +: 8]);
          pad_length();
        end
        msg_open = 0;
        finishes++;
        for (int i = 0; i < 4; i++) begin
          o.digest_word = chain[i];
          o.word_index  = 2'(i);
          o.final_word  = (i == 3);
          digest_q.push_back(o);
        end
      end
      default: ;
    endcase
  endfunction

  // Compare one delivered digest word with the oldest expectation.
  function void check_result(hmd5_pkg::out_item_t got);
    hmd5_pkg::out_item_t want;
    results_seen++;
    if (digest_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected digest word %h idx %0d final %0b",
                 got.digest_word, got.word_index, got.final_word);
      return;
    end
    want = digest_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("digest mismatch: want %h/%0d/%0b got %h/%0d/%0b",
                 want.digest_word, want.word_index, want.final_word,
                 got.digest_word, got.word_index, got.final_word);
    end
  endfunction
endclass

module md5_hmac_hash_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Quiet time after the last digest word before a mode write or the end; a
  // keyed open may still be running its key block.
  localparam int SETTLE_CYCLES = 12000;
  localparam int STALL_LIMIT   = 40000;
  localparam int LONG_HOLD     = 400;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  hmd5_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  hmd5_pkg::out_item_t out_data;
  logic                cfg_we;
  logic                cfg_wdata;

  hmac_md5_scoreboard sb;
  int in_idle_pct;
  int out_idle_pct;
  bit hold_req;
  int hold_left;
  int quiet_cycles;
  int items_sent;

  md5_hmac_hash_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Receiver side: random back-pressure, plus one long hold-off on request.
  always @(negedge clk) begin
    if (rst) begin
      out_ready = 0;
    end else if (hold_left > 0) begin
      out_ready = 0;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 0;
      hold_left = LONG_HOLD - 1;
      out_ready = 0;
    end else begin
      out_ready = ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Check every output transaction against the predictor.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("md5_hmac_hash_engine_tb: errors");
        $finish;
      end
    end
  end

  // Offer one input transaction; called and returns at a falling edge.
  task automatic send_item(input hmd5_pkg::cmd_t cmd, input logic [5:0] idx,
                           input logic [7:0] val);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid = 0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid          = 1;
    in_data.command   = cmd;
    in_data.key_index = idx;
    in_data.data_byte = val;
    do @(posedge clk); while (!in_ready);
    sb.note_input(in_data);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop valid, wait for all digest words, then let the engine go quiet.
  task automatic drain();
    in_valid = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mode(input bit m);
    drain();
    cfg_we    = 1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we = 0;
    sb.hmac_mode = m;
  endtask

  // Well-formed message with random content and some noise mixed in; the length is
  // trimmed so the item count stays near the budget.
  task automatic random_message(input int budget);
    int len;
    int room;
    len = ($urandom_range(5) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
    room = budget - items_sent;
    if (len > room) len = (room > 0) ? room : 0;
    repeat ($urandom_range(0, 3))
      send_item(hmd5_pkg::CMD_KEY, 6'($urandom_range(63)), 8'($urandom_range(255)));
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(19))
        0: send_item(hmd5_pkg::CMD_NONE, 6'($urandom_range(63)), 8'($urandom_range(255)));
        1: send_item(hmd5_pkg::CMD_KEY, 6'($urandom_range(63)), 8'($urandom_range(255)));
        default: ;
      endcase
      send_item(hmd5_pkg::CMD_BYTE, 6'($urandom_range(63)), 8'($urandom_range(255)));
    end
    send_item(hmd5_pkg::CMD_FINISH, 6'($urandom_range(63)), 8'($urandom_range(255)));
  endtask

  initial begin
    sb           = new();
    rst          = 1;
    in_valid     = 0;
    in_data      = '0;
    cfg_we       = 0;
    cfg_wdata    = 0;
    hold_req     = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    items_sent   = 0;
    in_idle_pct  = 28;
    out_idle_pct = 60;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: plain MD5, key store extremes, empty message, unused command.
    write_mode(0);
    send_item(hmd5_pkg::CMD_KEY, 6'd0, 8'hFF);
    send_item(hmd5_pkg::CMD_KEY, 6'd63, 8'h00);
    send_item(hmd5_pkg::CMD_FINISH, 6'd63, 8'hFF);
    send_item(hmd5_pkg::CMD_BYTE, 6'd0, 8'h00);
    send_item(hmd5_pkg::CMD_BYTE, 6'd63, 8'hFF);
    send_item(hmd5_pkg::CMD_NONE, 6'd63, 8'hFF);
    send_item(hmd5_pkg::CMD_FINISH, 6'd0, 8'h00);

    // Directed: keyed mode, empty message, key write while a message is open.
    write_mode(1);
    send_item(hmd5_pkg::CMD_FINISH, 6'd0, 8'h00);
    send_item(hmd5_pkg::CMD_KEY, 6'd63, 8'hFF);
    send_item(hmd5_pkg::CMD_BYTE, 6'd0, 8'h5A);
    send_item(hmd5_pkg::CMD_KEY, 6'd1, 8'h11);
    send_item(hmd5_pkg::CMD_FINISH, 6'd0, 8'h00);

    // Directed: flip the mode inside an open message, both directions.
    send_item(hmd5_pkg::CMD_BYTE, 6'd0, 8'hA5);
    write_mode(0);
    send_item(hmd5_pkg::CMD_BYTE, 6'd0, 8'h3C);
    send_item(hmd5_pkg::CMD_FINISH, 6'd0, 8'h00);
    send_item(hmd5_pkg::CMD_BYTE, 6'd0, 8'hC3);
    write_mode(1);
    send_item(hmd5_pkg::CMD_FINISH, 6'd0, 8'h00);

    // Random phases: receiver-heavy idling, then sender-heavy, then none.
    for (int ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 0) ? 28 : (ph == 1) ? 60 : 0;
      out_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 28 : 0;
      for (int m = 0; m < 2; m++) begin
        write_mode(m[0] ^ ph[0]);
        if (ph == 2 && m == 0) begin
          // Stall the receiver while the sender keeps pushing past a finish.
          hold_req = 1;
          send_item(hmd5_pkg::CMD_BYTE, 6'd5, 8'h42);
          send_item(hmd5_pkg::CMD_FINISH, 6'd0, 8'h00);
          repeat (8)
            send_item(hmd5_pkg::CMD_BYTE, 6'($urandom_range(63)), 8'($urandom_range(255)));
          send_item(hmd5_pkg::CMD_FINISH, 6'd0, 8'h00);
        end
        while (items_sent < 20 + (ph * 2 + m + 1) * 32)
          random_message(20 + (ph * 2 + m + 1) * 32);
      end
    end

    drain();
    while (sb.pending() != 0) void'(sb.digest_q.pop_front());
    $display("run covered %0d input transactions, %0d finished messages, %0d digest words",
             items_sent, sb.finishes, sb.results_seen);
    $display("plain and keyed modes, mode flips inside messages, long receiver hold-off");
    if (sb.mismatches == 0 && sb.results_seen == 4 * sb.finishes) begin
      $display("md5_hmac_hash_engine_tb: clean");
    end else begin
      $display("%0d mismatches, %0d words missing", sb.mismatches,
               4 * sb.finishes - sb.results_seen);
      $display("md5_hmac_hash_engine_tb: errors");
    end
    $finish;
  end
endmodule

`default_nettype wire
